// ===== rtl/sqb5_pkg.sv =====
`timescale 1ns / 1ps
package sqb5_pkg;

	localparam int SAMPLE_BITS_DEF = 32;
	localparam int MAX_SAMPLES_DEF = 1024;
	localparam int OUT_BITS        = 32;
	localparam int CFG_IDX_BITS    = 2;
	localparam int CFG_DATA_BITS   = 14;
	localparam int COUNT_BITS      = 11;
	localparam int LEVEL_BITS      = 14;
	localparam int PCT_BITS        = 15;
	localparam int FRAC_BITS       = 16;
	localparam int REM_BITS        = 10;
	localparam int POS_SHIFT       = 11;
	localparam int QIDX_BITS       = 3;
	localparam int NUM_Q           = 5;

	typedef logic [CFG_IDX_BITS-1:0] cfg_idx_t;
	localparam cfg_idx_t CFG_SAMPLE_COUNT = 2'd0;
	localparam cfg_idx_t CFG_BAND_A       = 2'd1;
	localparam cfg_idx_t CFG_BAND_B       = 2'd2;

	localparam logic [COUNT_BITS-1:0] COUNT_RESET   = 11'd1024;
	localparam logic [LEVEL_BITS-1:0] LEVEL_A_RESET = 14'd6800;
	localparam logic [LEVEL_BITS-1:0] LEVEL_B_RESET = 14'd9000;
	localparam logic [LEVEL_BITS-1:0] LEVEL_MAX     = 14'd10000;
	localparam logic [PCT_BITS-1:0]   PCT_MID       = 15'd10000;
	// 65536 / 20000 reduced to 2^POS_SHIFT / POS_DEN
	localparam logic [REM_BITS-1:0]   POS_DEN       = 10'd625;

	typedef logic [QIDX_BITS-1:0] qidx_t;
	localparam qidx_t Q_UPPER_A = 3'd0;
	localparam qidx_t Q_LOWER_A = 3'd1;
	localparam qidx_t Q_UPPER_B = 3'd2;
	localparam qidx_t Q_LOWER_B = 3'd3;
	localparam qidx_t Q_MEDIAN  = 3'd4;

	typedef enum logic [10:0] {
		ST_COLLECT    = 11'b000_0000_0001,
		ST_PASS_START = 11'b000_0000_0010,
		ST_MERGE      = 11'b000_0000_0100,
		ST_PASS_END   = 11'b000_0000_1000,
		ST_Q_MUL      = 11'b000_0001_0000,
		ST_Q_DIV      = 11'b000_0010_0000,
		ST_Q_READ     = 11'b000_0100_0000,
		ST_Q_DIFF     = 11'b000_1000_0000,
		ST_Q_PROD     = 11'b001_0000_0000,
		ST_Q_SUM      = 11'b010_0000_0000,
		ST_DONE       = 11'b100_0000_0000
	} state_t;

	typedef struct packed {
		logic store;
		logic pass_start;
		logic merge;
		logic pass_end;
		logic q_mul;
		logic q_div_step;
		logic q_read;
		logic q_diff;
		logic q_prod;
		logic q_sum;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic sort_done;
		logic pass_last;
		logic div_done;
		logic q_last;
	} status_t;

endpackage

// ===== rtl/sorted_quantile_bands_five.sv =====
`timescale 1ns / 1ps
// Collects signed Q16.16 bootstrap samples of one cell, one item per cycle, until
// sample_count samples are held; then sorts them by bottom-up merge passes between
// two sample banks with two read ports each, then gives one item with five
// linearly interpolated quantiles. While a cell is sorted and interpolated, and until
// its item is taken into the output register, in_stall is high. A cell of n samples is
// sorted in ceil(log2 n) merge passes; then each of the five quantiles is found by a
// multiply, three steps of the position divide done by reciprocal multiplies, a read,
// a difference, a product and a sum, and the item goes to the output register once it is free.
module sorted_quantile_bands_five #(
	parameter int MAX_SAMPLES = sqb5_pkg::MAX_SAMPLES_DEF,
	parameter int SAMPLE_BITS = sqb5_pkg::SAMPLE_BITS_DEF
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    cfg_valid,
	output logic                                    cfg_ready,
	input  logic [sqb5_pkg::CFG_IDX_BITS-1:0]       cfg_index,
	input  logic [sqb5_pkg::CFG_DATA_BITS-1:0]      cfg_data,
	input  logic                                    in_valid,
	output logic                                    in_stall,
	input  logic signed [SAMPLE_BITS-1:0]           sample_value,
	output logic                                    out_valid,
	input  logic                                    out_stall,
	output logic signed [sqb5_pkg::OUT_BITS-1:0]    upper_a,
	output logic signed [sqb5_pkg::OUT_BITS-1:0]    lower_a,
	output logic signed [sqb5_pkg::OUT_BITS-1:0]    upper_b,
	output logic signed [sqb5_pkg::OUT_BITS-1:0]    lower_b,
	output logic signed [sqb5_pkg::OUT_BITS-1:0]    median_value
);
	import sqb5_pkg::*;

	localparam int PW = $clog2(MAX_SAMPLES + 1);
	localparam int XW = (PW > COUNT_BITS) ? PW : COUNT_BITS;

	logic [COUNT_BITS-1:0] count_q;
	logic [LEVEL_BITS-1:0] level_a_q, level_b_q, level_sat;
	logic [XW-1:0]         count_x;
	logic [PW-1:0]         n_eff;
	cmd_t                  cmd;
	status_t               sts;

	assign cfg_ready = 1'b1;
	assign level_sat = (cfg_data > LEVEL_MAX) ? LEVEL_MAX : cfg_data;

	always_comb begin
		count_x = XW'(count_q);
		if (count_x == '0) begin
			n_eff = PW'(1);
		end else if (count_x > XW'(MAX_SAMPLES)) begin
			n_eff = PW'(MAX_SAMPLES);
		end else begin
			n_eff = PW'(count_x);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= COUNT_RESET;
			level_a_q <= LEVEL_A_RESET;
			level_b_q <= LEVEL_B_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_SAMPLE_COUNT: count_q   <= cfg_data[COUNT_BITS-1:0];
				CFG_BAND_A:       level_a_q <= level_sat;
				CFG_BAND_B:       level_b_q <= level_sat;
				default: ;
			endcase
		end
	end

	sqb5_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	sqb5_dp #(
		.MAX_SAMPLES (MAX_SAMPLES),
		.SAMPLE_BITS (SAMPLE_BITS),
		.PW          (PW)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.sample_value (sample_value),
		.n_eff        (n_eff),
		.level_a      (level_a_q),
		.level_b      (level_b_q),
		.upper_a      (upper_a),
		.lower_a      (lower_a),
		.upper_b      (upper_b),
		.lower_b      (lower_b),
		.median_value (median_value)
	);

endmodule

// ===== rtl/sqb5_dp.sv =====
`timescale 1ns / 1ps
module sqb5_dp #(
	parameter int MAX_SAMPLES = sqb5_pkg::MAX_SAMPLES_DEF,
	parameter int SAMPLE_BITS = sqb5_pkg::SAMPLE_BITS_DEF,
	parameter int PW          = $clog2(MAX_SAMPLES + 1)
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  sqb5_pkg::cmd_t                       cmd,
	output sqb5_pkg::status_t                    sts,
	input  logic signed [SAMPLE_BITS-1:0]        sample_value,
	input  logic [PW-1:0]                        n_eff,
	input  logic [sqb5_pkg::LEVEL_BITS-1:0]      level_a,
	input  logic [sqb5_pkg::LEVEL_BITS-1:0]      level_b,
	output logic signed [sqb5_pkg::OUT_BITS-1:0] upper_a,
	output logic signed [sqb5_pkg::OUT_BITS-1:0] lower_a,
	output logic signed [sqb5_pkg::OUT_BITS-1:0] upper_b,
	output logic signed [sqb5_pkg::OUT_BITS-1:0] lower_b,
	output logic signed [sqb5_pkg::OUT_BITS-1:0] median_value
);
	import sqb5_pkg::*;

	localparam int SW  = SAMPLE_BITS;
	localparam int IW  = $clog2(MAX_SAMPLES);
	localparam int EW  = PW + 2;
	localparam int WW  = PW + 1;
	localparam int PBW = PCT_BITS + PW;
	localparam int DW  = PBW + FRAC_BITS;
	localparam int DCW = 2;
	localparam int DIV_LAST = 2;
	localparam int RW  = (SW > OUT_BITS) ? SW : OUT_BITS;
	localparam int DFW = (SW + 1 > FRAC_BITS + 1) ? SW + 1 : FRAC_BITS + 1;
	localparam int S1  = PBW + 10;
	localparam int RSW = REM_BITS + POS_SHIFT;
	localparam int S2  = RSW + 10;
	localparam logic [PBW:0] RCP1 =
		(PBW+1)'(((64'd1 << S1) + 64'(POS_DEN) - 64'd1) / 64'(POS_DEN));
	localparam logic [RSW:0] RCP2 =
		(RSW+1)'(((64'd1 << S2) + 64'(POS_DEN) - 64'd1) / 64'(POS_DEN));

	logic [SW-1:0] bank0 [MAX_SAMPLES];
	logic [SW-1:0] bank1 [MAX_SAMPLES];
	logic [SW-1:0] rd0_a_q, rd0_b_q, rd1_a_q, rd1_b_q;

	logic [PW-1:0]  seen_q;
	logic [WW-1:0]  w_q;
	logic           src_q;
	logic [EW-1:0]  pa_q, pb_q, out_q, base_q;
	logic [EW-1:0]  pa_n, pb_n, out_n, base_n;
	logic [DW-1:0]  dq_q;
	logic [PBW-1:0] p_q, u_q;
	logic [REM_BITS-1:0] r_q;
	logic [DCW-1:0] dcnt_q;
	qidx_t          k_q;
	logic [RW-1:0]  a_q;
	logic [DFW-1:0] diff_q, hp_q;
	logic [FRAC_BITS-1:0] lp_q;
	logic [OUT_BITS-1:0] res_q [NUM_Q];

	logic [EW-1:0] n_x, ea_raw, ea, eb_raw, eb, nb, nb_w, out_inc, w_x;
	logic [EW-1:0] lo, lo_c, lo_p1;
	logic [PW-1:0] seen_inc;
	logic          a_ok, b_ok, take_a, pair_end, single, store_we;
	logic [SW-1:0] da, db, wr_val;
	logic [IW-1:0] addr_a, addr_b;
	logic [PCT_BITS-1:0] pct;
	logic [PBW-1:0] prod;
	logic [2*PBW:0] q1_prod;
	logic [PBW-1:0] u_n;
	logic [REM_BITS-1:0] r_n;
	logic [RSW-1:0] r_sh;
	logic [2*RSW:0] q2_prod;
	logic [POS_SHIFT-1:0] qf;
	logic [DW-1:0] pos_n;
	logic [FRAC_BITS-1:0] f;
	logic [DFW-1:0] hi_prod, t_sum;
	logic [2*FRAC_BITS-1:0] lo_prod;
	logic [RW-1:0] sum;

	always_comb begin
		n_x      = EW'(n_eff);
		w_x      = EW'(w_q);
		seen_inc = seen_q + 1'b1;
		store_we = cmd.store && ({1'b0, seen_q} < (PW+1)'(MAX_SAMPLES));
		da       = src_q ? rd1_a_q : rd0_a_q;
		db       = src_q ? rd1_b_q : rd0_b_q;
		ea_raw   = base_q + w_x;
		ea       = (ea_raw < n_x) ? ea_raw : n_x;
		nb       = base_q + (w_x << 1);
		eb_raw   = nb;
		eb       = (eb_raw < n_x) ? eb_raw : n_x;
		nb_w     = nb + w_x;
		a_ok     = pa_q < ea;
		b_ok     = pb_q < eb;
		take_a   = a_ok && (!b_ok || ($signed(da) <= $signed(db)));
		wr_val   = take_a ? da : db;
		out_inc  = out_q + 1'b1;
		pair_end = out_inc == eb;

		pa_n   = pa_q;
		pb_n   = pb_q;
		out_n  = out_q;
		base_n = base_q;
		if (cmd.pass_start) begin
			base_n = '0;
			pa_n   = '0;
			pb_n   = (w_x < n_x) ? w_x : n_x;
			out_n  = '0;
		end else if (cmd.merge) begin
			out_n = out_inc;
			if (pair_end) begin
				base_n = nb;
				pa_n   = nb;
				pb_n   = (nb_w < n_x) ? nb_w : n_x;
			end else if (take_a) begin
				pa_n = pa_q + 1'b1;
			end else begin
				pb_n = pb_q + 1'b1;
			end
		end

		lo     = dq_q[FRAC_BITS +: EW];
		f      = dq_q[FRAC_BITS-1:0];
		lo_c   = (lo >= n_x) ? n_x - 1'b1 : lo;
		lo_p1  = lo_c + 1'b1;
		single = lo_p1 >= n_x;
		addr_a = cmd.q_read ? lo_c[IW-1:0] : pa_n[IW-1:0];
		addr_b = cmd.q_read ? lo_p1[IW-1:0] : pb_n[IW-1:0];

		case (k_q)
			Q_UPPER_A: pct = PCT_MID + PCT_BITS'(level_a);
			Q_LOWER_A: pct = PCT_MID - PCT_BITS'(level_a);
			Q_UPPER_B: pct = PCT_MID + PCT_BITS'(level_b);
			Q_LOWER_B: pct = PCT_MID - PCT_BITS'(level_b);
			default:   pct = PCT_MID;
		endcase
		prod = PBW'(pct) * PBW'(n_eff - 1'b1);

		// position = floor(prod * 2048 / 625) as quotient and remainder steps
		q1_prod = (2*PBW+1)'(p_q) * (2*PBW+1)'(RCP1);
		u_n     = PBW'(q1_prod >> S1);
		r_n     = REM_BITS'(p_q - u_q * PBW'(POS_DEN));
		r_sh    = {r_q, POS_SHIFT'(0)};
		q2_prod = (2*RSW+1)'(r_sh) * (2*RSW+1)'(RCP2);
		qf      = POS_SHIFT'(q2_prod >> S2);
		pos_n   = (DW'(u_q) << POS_SHIFT) + DW'(qf);

		hi_prod = DFW'(diff_q[DFW-1:FRAC_BITS]) * DFW'(f);
		lo_prod = (2*FRAC_BITS)'(diff_q[FRAC_BITS-1:0]) * (2*FRAC_BITS)'(f);
		t_sum   = hp_q + DFW'(lp_q);
		sum     = a_q + RW'(t_sum);

		sts.full      = seen_inc >= n_eff;
		sts.sort_done = w_x >= n_x;
		sts.pass_last = out_inc == n_x;
		sts.div_done  = dcnt_q == DCW'(DIV_LAST);
		sts.q_last    = k_q == Q_MEDIAN;
	end

	// sample banks, two read ports each
	always_ff @(posedge clk) begin
		if (store_we || (cmd.merge && src_q)) begin
			bank0[cmd.store ? seen_q[IW-1:0] : out_q[IW-1:0]] <= cmd.store ? sample_value : wr_val;
		end
		rd0_a_q <= bank0[addr_a];
		rd0_b_q <= bank0[addr_b];
	end

	always_ff @(posedge clk) begin
		if (cmd.merge && !src_q) begin
			bank1[out_q[IW-1:0]] <= wr_val;
		end
		rd1_a_q <= bank1[addr_a];
		rd1_b_q <= bank1[addr_b];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= '0;
			w_q    <= '0;
			src_q  <= 1'b0;
			pa_q   <= '0;
			pb_q   <= '0;
			out_q  <= '0;
			base_q <= '0;
			dcnt_q <= '0;
			k_q    <= Q_UPPER_A;
		end else begin
			pa_q   <= pa_n;
			pb_q   <= pb_n;
			out_q  <= out_n;
			base_q <= base_n;
			if (cmd.store) begin
				seen_q <= sts.full ? '0 : seen_inc;
				w_q    <= WW'(1);
				src_q  <= 1'b0;
				k_q    <= Q_UPPER_A;
			end
			if (cmd.pass_end) begin
				w_q   <= w_q << 1;
				src_q <= !src_q;
			end
			if (cmd.q_mul) begin
				dcnt_q <= '0;
			end else if (cmd.q_div_step) begin
				dcnt_q <= dcnt_q + 1'b1;
			end
			if (cmd.q_sum) begin
				k_q <= k_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.q_mul) begin
			p_q <= prod;
		end else if (cmd.q_div_step) begin
			if (dcnt_q == '0) begin
				u_q <= u_n;
			end else if (dcnt_q == DCW'(1)) begin
				r_q <= r_n;
			end else begin
				dq_q <= pos_n;
			end
		end
		if (cmd.q_diff) begin
			a_q    <= RW'($signed(da));
			diff_q <= single ? '0 : DFW'($signed(db)) - DFW'($signed(da));
		end
		if (cmd.q_prod) begin
			hp_q <= hi_prod;
			lp_q <= lo_prod[2*FRAC_BITS-1:FRAC_BITS];
		end
		if (cmd.q_sum) begin
			res_q[k_q] <= sum[OUT_BITS-1:0];
		end
		if (cmd.load_out) begin
			upper_a      <= res_q[Q_UPPER_A];
			lower_a      <= res_q[Q_LOWER_A];
			upper_b      <= res_q[Q_UPPER_B];
			lower_b      <= res_q[Q_LOWER_B];
			median_value <= res_q[Q_MEDIAN];
		end
	end

	a_merge_live: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.merge |-> (a_ok || b_ok)) else $error("merge with both runs empty");
	a_lo_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.q_read |-> (lo_c < n_x)) else $error("quantile index out of range");
	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.q_div_step && dcnt_q == DCW'(1)) |=> (r_q < POS_DEN))
		else $error("divider remainder too large");

endmodule

// ===== rtl/sqb5_ctrl.sv =====
`timescale 1ns / 1ps
module sqb5_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	output logic              out_valid,
	input  logic              out_stall,
	input  sqb5_pkg::status_t sts,
	output sqb5_pkg::cmd_t    cmd
);
	import sqb5_pkg::*;

	state_t state_q, state_n;
	logic   out_valid_q;
	logic   accept, out_free;

	always_comb begin
		in_stall  = state_q != ST_COLLECT;
		accept    = in_valid && !in_stall;
		out_valid = out_valid_q;
		out_free  = !out_valid_q || !out_stall;
		cmd       = '0;
		state_n   = state_q;
		case (state_q)
			ST_COLLECT: begin
				cmd.store = accept;
				if (accept && sts.full) begin
					state_n = ST_PASS_START;
				end
			end
			ST_PASS_START: begin
				cmd.pass_start = 1'b1;
				state_n = sts.sort_done ? ST_Q_MUL : ST_MERGE;
			end
			ST_MERGE: begin
				cmd.merge = 1'b1;
				if (sts.pass_last) begin
					state_n = ST_PASS_END;
				end
			end
			ST_PASS_END: begin
				cmd.pass_end = 1'b1;
				state_n = ST_PASS_START;
			end
			ST_Q_MUL: begin
				cmd.q_mul = 1'b1;
				state_n = ST_Q_DIV;
			end
			ST_Q_DIV: begin
				cmd.q_div_step = 1'b1;
				if (sts.div_done) begin
					state_n = ST_Q_READ;
				end
			end
			ST_Q_READ: begin
				cmd.q_read = 1'b1;
				state_n = ST_Q_DIFF;
			end
			ST_Q_DIFF: begin
				cmd.q_diff = 1'b1;
				state_n = ST_Q_PROD;
			end
			ST_Q_PROD: begin
				cmd.q_prod = 1'b1;
				state_n = ST_Q_SUM;
			end
			ST_Q_SUM: begin
				cmd.q_sum = 1'b1;
				state_n = sts.q_last ? ST_DONE : ST_Q_MUL;
			end
			ST_DONE: begin
				cmd.load_out = out_free;
				if (out_free) begin
					state_n = ST_COLLECT;
				end
			end
			default: state_n = ST_COLLECT;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_COLLECT;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_out_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_DONE)) else $error("item shown outside done");
	a_cell_to_sort: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && sts.full) |=> (state_q == ST_PASS_START)) else $error("full cell not sorted");
	a_merge_exit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MERGE) |=> (state_q == ST_MERGE || state_q == ST_PASS_END))
		else $error("merge left early");

endmodule

// ===== tb/sv/sorted_quantile_bands_five_tb.sv =====
`timescale 1ns / 1ps
module sorted_quantile_bands_five_tb;
	import sqb5_pkg::*;

	localparam int STORE_DEPTH = MAX_SAMPLES_DEF;
	localparam int CYCLE_LIMIT = 1500000;
	localparam int ITEM_TARGET = 550;

	typedef struct packed {
		logic signed [OUT_BITS-1:0] upper_a;
		logic signed [OUT_BITS-1:0] lower_a;
		logic signed [OUT_BITS-1:0] upper_b;
		logic signed [OUT_BITS-1:0] lower_b;
		logic signed [OUT_BITS-1:0] median_value;
	} band_set_t;

	class band_scoreboard;
		logic signed [31:0] store [STORE_DEPTH];
		int unsigned seen;
		int unsigned count_reg;
		int unsigned level_a;
		int unsigned level_b;
		band_set_t expected_bands[$];
		int mismatches;

		function new();
			seen = 0;
			count_reg = COUNT_RESET;
			level_a = LEVEL_A_RESET;
			level_b = LEVEL_B_RESET;
			mismatches = 0;
			foreach (store[i]) store[i] = '0;
		endfunction

		function void write_reg(cfg_idx_t idx, logic [CFG_DATA_BITS-1:0] data);
			int unsigned v;
			if (idx == CFG_SAMPLE_COUNT) begin
				count_reg = data & 14'h7ff;
			end else if (idx == CFG_BAND_A || idx == CFG_BAND_B) begin
				v = data;
				if (v > LEVEL_MAX) v = LEVEL_MAX;
				if (idx == CFG_BAND_A) level_a = v;
				else level_b = v;
			end
		endfunction

		function logic signed [31:0] quantile(int unsigned n, int unsigned pct);
			longint unsigned pos;
			longint unsigned lo;
			longint f;
			longint acc;
			pos = (longint'(pct) * longint'(n - 1) * 65536) / 20000;
			lo = pos >> 16;
			f = pos & 16'hffff;
			if (lo >= n) lo = n - 1;
			if (lo + 1 >= n) return store[lo];
			acc = longint'(store[lo]) * (65536 - f) + longint'(store[lo + 1]) * f;
			return 32'(acc >>> 16);
		endfunction

		function void note_sample(logic signed [31:0] v);
			int unsigned n;
			int unsigned j;
			logic signed [31:0] key;
			band_set_t b;
			n = count_reg;
			if (n < 1) n = 1;
			if (n > STORE_DEPTH) n = STORE_DEPTH;
			if (seen < STORE_DEPTH) store[seen] = v;
			seen = (seen + 1) & 11'h7ff;
			if (seen < n) return;
			seen = 0;
			for (int unsigned i = 1; i < n; i++) begin
				key = store[i];
				j = i;
				while (j > 0 && store[j - 1] > key) begin
					store[j] = store[j - 1];
					j--;
				end
				store[j] = key;
			end
			b.upper_a = quantile(n, 10000 + level_a);
			b.lower_a = quantile(n, 10000 - level_a);
			b.upper_b = quantile(n, 10000 + level_b);
			b.lower_b = quantile(n, 10000 - level_b);
			b.median_value = quantile(n, 10000);
			expected_bands.push_back(b);
		endfunction

		function void check_bands(band_set_t got);
			band_set_t want;
			if (expected_bands.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected item: %h", got);
				return;
			end
			want = expected_bands.pop_front();
			if (got !== want) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: expected ua %0d la %0d ub %0d lb %0d med %0d, got ua %0d la %0d ub %0d lb %0d med %0d",
						want.upper_a, want.lower_a, want.upper_b, want.lower_b, want.median_value,
						got.upper_a, got.lower_a, got.upper_b, got.lower_b, got.median_value);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic cfg_valid;
	logic cfg_ready;
	cfg_idx_t cfg_index;
	logic [CFG_DATA_BITS-1:0] cfg_data;
	logic in_valid;
	logic in_stall;
	logic signed [31:0] sample_value;
	logic out_valid;
	logic out_stall;
	logic signed [31:0] upper_a, lower_a, upper_b, lower_b, median_value;

	band_scoreboard sb;
	int cycles;
	int items_sent;
	bit quiet;
	int hold_req;

	sorted_quantile_bands_five dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall), .sample_value(sample_value),
		.out_valid(out_valid), .out_stall(out_stall),
		.upper_a(upper_a), .lower_a(lower_a), .upper_b(upper_b), .lower_b(lower_b),
		.median_value(median_value)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("sorted_quantile_bands_five_tb failed");
			$finish;
		end
	end

	// receiver: checks items, random stall, long hold-off on request
	int hold_left;
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_bands({upper_a, lower_a, upper_b, lower_b, median_value});
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (hold_req > 0) begin
			out_stall <= 1'b1;
			hold_left <= hold_req;
			hold_req <= 0;
		end else begin
			out_stall <= !quiet && ($urandom_range(99) < 6);
		end
	end

	task automatic write_cfg(int unsigned cnt, int unsigned la, int unsigned lb);
		cfg_idx_t idx [3];
		logic [CFG_DATA_BITS-1:0] val [3];
		idx[0] = CFG_SAMPLE_COUNT; val[0] = CFG_DATA_BITS'(cnt);
		idx[1] = CFG_BAND_A;       val[1] = CFG_DATA_BITS'(la);
		idx[2] = CFG_BAND_B;       val[2] = CFG_DATA_BITS'(lb);
		for (int k = 0; k < 3; k++) begin
			cfg_valid <= 1'b1;
			cfg_index <= idx[k];
			cfg_data <= val[k];
			do @(posedge clk); while (!cfg_ready);
			sb.write_reg(idx[k], val[k]);
		end
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_sample(logic signed [31:0] v);
		if (!quiet && $urandom_range(99) < 6) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_valid <= 1'b1;
		sample_value <= v;
		do @(posedge clk); while (in_stall);
		sb.note_sample(v);
		items_sent++;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (sb.expected_bands.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	function automatic logic signed [31:0] rand_sample();
		case ($urandom_range(4))
			0: return $urandom_range(20) - 10;
			1: return 32'sh8000_0000 + $urandom_range(3);
			2: return 32'sh7fff_ffff - $urandom_range(3);
			default: return $urandom;
		endcase
	endfunction

	logic signed [31:0] edge_vals [8];
	int unsigned cnt, la, lb, cells;

	initial begin
		sb = new();
		clk = 1'b0;
		cycles = 0;
		items_sent = 0;
		quiet = 1'b0;
		hold_req = 0;
		hold_left = 0;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = CFG_SAMPLE_COUNT;
		cfg_data = '0;
		in_valid = 1'b0;
		sample_value = '0;
		out_stall = 1'b0;
		edge_vals = '{32'sh8000_0000, 32'sh7fff_ffff, 0, -1, 1, 32'sh0001_0000,
			32'sh8000_0000, 32'sh7fff_ffff};
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: single-sample cells, count zero, saturated level
		write_cfg(1, 0, 10000);
		foreach (edge_vals[i]) send_sample(edge_vals[i]);
		drain();
		write_cfg(0, 16383, 1);
		send_sample(32'sh8000_0000);
		send_sample(32'sh7fff_ffff);
		drain();
		write_cfg(2, 16383, 1);
		for (int i = 0; i < 4; i++) send_sample(edge_vals[i]);
		drain();
		write_cfg(5, 10000, 0);
		for (int i = 0; i < 5; i++) send_sample(edge_vals[7 - i]);
		drain();
		// count lowered mid-cell
		write_cfg(8, 5000, 9999);
		for (int i = 0; i < 5; i++) send_sample(rand_sample());
		drain();
		write_cfg(3, 5000, 9999);
		send_sample(32'sh7fff_ffff);
		drain();

		for (int ph = 0; items_sent < ITEM_TARGET; ph++) begin
			case ($urandom_range(5))
				0: cnt = $urandom_range(1, 2);
				1: cnt = $urandom_range(20, 64);
				default: cnt = $urandom_range(3, 12);
			endcase
			la = ($urandom_range(3) == 0) ? ($urandom_range(1) ? 0 : 16383) : $urandom_range(10000);
			lb = ($urandom_range(3) == 0) ? ($urandom_range(1) ? 10000 : 10001) : $urandom;
			write_cfg(cnt, la, lb & 16'h3fff);
			quiet = (ph >= 10 && ph < 20);
			if (ph == 5) hold_req = 3000;
			cells = $urandom_range(1, 4);
			for (int i = 0; i < cnt * cells; i++) send_sample(rand_sample());
			if ($urandom_range(4) == 0)
				for (int i = 0; i < $urandom_range(1, cnt); i++) send_sample(rand_sample());
			drain();
		end
		quiet = 1'b0;
		// finish any partial cell so nothing is left in the store
		write_cfg(1, 6800, 9000);
		send_sample(rand_sample());
		drain();

		if (sb.mismatches == 0 && sb.expected_bands.size() == 0)
			$display("sorted_quantile_bands_five_tb passed");
		else
			$display("sorted_quantile_bands_five_tb failed");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/sqb5_pkg.sv
rtl/sqb5_dp.sv
rtl/sqb5_ctrl.sv
rtl/sorted_quantile_bands_five.sv
tb/sv/sorted_quantile_bands_five_tb.sv
